FILE: hw/rtl/priority_decay_process_scheduler_defines.svh
// Assertion macros used by the scheduler checker.
`ifndef PRIORITY_DECAY_PROCESS_SCHEDULER_DEFINES_SVH
`define PRIORITY_DECAY_PROCESS_SCHEDULER_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define PDPS_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("scheduler port check failed");

// Next-cycle implication, gated off during reset.
`define PDPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("scheduler port check failed");

`endif

FILE: hw/rtl/pdps_pkg.sv
`default_nettype none
package pdps_pkg;
	localparam int TABLE_ENTRIES = 8;
	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PRI_W = 12;
	localparam logic signed [PRI_W-1:0] PRI_MIN = {1'b1, {(PRI_W-1){1'b0}}};

	// Action codes
	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_DISP   = 2'd2;
	localparam logic [1:0] ST_NONE   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_SLICE   = 2'd0;
	localparam logic [1:0] CFG_BASE    = 2'd1;
	localparam logic [1:0] CFG_PENALTY = 2'd2;

	localparam logic [7:0] SLICE_RST   = 8'd2;
	localparam logic [7:0] BASE_RST    = 8'd50;
	localparam logic [3:0] PENALTY_RST = 4'd3;

	// Token that walks down the row of cells, one cell per cycle
	typedef struct packed {
		logic                    active;
		logic                    dispatch;
		logic                    found;
		logic [SLOT_W-1:0]       slot;
		logic [7:0]              id;
		logic signed [PRI_W-1:0] pri;
		logic [7:0]              used;
		logic [7:0]              rem;
		logic [7:0]              runs;
	} tok_t;

	// Write-back of a dispatched entry
	typedef struct packed {
		logic                    en;
		logic [SLOT_W-1:0]       slot;
		logic signed [PRI_W-1:0] pri;
		logic [7:0]              used;
		logic [7:0]              rem;
		logic [7:0]              runs;
		logic                    done;
	} upd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pdps_cell.sv
`default_nettype none
module pdps_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pdps_pkg::SLOT_W-1:0]   slot_idx,
	input  pdps_pkg::tok_t                tok_in,
	input  pdps_pkg::upd_t                upd,
	output pdps_pkg::tok_t                tok_out
);
	import pdps_pkg::*;

	logic                    valid_q;
	logic [7:0]              id_q;
	logic signed [PRI_W-1:0] pri_q;
	logic [7:0]              used_q;
	logic [7:0]              rem_q;
	logic [7:0]              runs_q;
	logic                    claim;
	logic                    better;
	logic                    hit;
	tok_t                    tok_nxt;
	tok_t                    tok_q;

	// Claim a free slot on load, or take over the candidate on dispatch
	always_comb begin
		claim  = tok_in.active && (tok_in.dispatch == ACT_LOAD) && !tok_in.found && !valid_q;
		better = tok_in.active && (tok_in.dispatch == ACT_DISPATCH) && valid_q &&
			(!tok_in.found || (pri_q > tok_in.pri) ||
			 ((pri_q == tok_in.pri) && (id_q < tok_in.id)));
		hit    = upd.en && (upd.slot == slot_idx);
		tok_nxt = tok_in;
		if (claim) begin
			tok_nxt.found = 1'b1;
			tok_nxt.slot  = slot_idx;
		end
		if (better) begin
			tok_nxt.found = 1'b1;
			tok_nxt.slot  = slot_idx;
			tok_nxt.id    = id_q;
			tok_nxt.pri   = pri_q;
			tok_nxt.used  = used_q;
			tok_nxt.rem   = rem_q;
			tok_nxt.runs  = runs_q;
		end
	end

	// Occupancy: set on claim, drop when the process finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (hit && upd.done) begin
			valid_q <= 1'b0;
		end
	end

	// Entry contents
	always_ff @(posedge clk) begin
		if (claim) begin
			id_q   <= tok_in.id;
			pri_q  <= tok_in.pri;
			used_q <= tok_in.used;
			rem_q  <= tok_in.rem;
			runs_q <= tok_in.runs;
		end else if (hit) begin
			pri_q  <= upd.pri;
			used_q <= upd.used;
			rem_q  <= upd.rem;
			runs_q <= upd.runs;
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;
endmodule
`default_nettype wire

FILE: hw/rtl/priority_decay_process_scheduler.sv
// Dynamic priority scheduler over a table of TABLE_ENTRIES process slots, one slot per cell
// in a row. Each request (load or dispatch) walks the row one cell per cycle: a load is
// stored in the lowest free slot, a dispatch collects the best slot (highest priority, then
// smallest id, then lowest slot), and once the output is free the token caught at the end of
// the row writes the dispatched slot back and presents the result. One request is in the
// row at a time, and the next is taken while the previous result waits on the output.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none
module priority_decay_process_scheduler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [7:0]                         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [7:0]                         process_id,
	input  logic [7:0]                         need_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [7:0]                         chosen_id,
	output logic [7:0]                         used_time,
	output logic [7:0]                         remaining_time,
	output logic [7:0]                         run_count,
	output logic signed [pdps_pkg::PRI_W-1:0]  priority_res,
	output logic                               finished
);
	import pdps_pkg::*;

	logic [7:0]              slice_q;
	logic [7:0]              base_q;
	logic [3:0]              penalty_q;
	logic                    busy_q;
	logic                    pend_q;
	logic                    out_valid_q;
	tok_t                    tail_q;
	tok_t                    chain [0:TABLE_ENTRIES];
	upd_t                    upd;
	logic                    accept;
	logic                    fin_go;
	logic [7:0]              run_len;
	logic signed [PRI_W:0]   pri_dec;
	logic signed [PRI_W-1:0] pri_new;
	logic [8:0]              used_sum;
	logic [7:0]              used_new;
	logic [7:0]              rem_new;
	logic [7:0]              runs_new;
	logic                    done;
	logic [1:0]              status_q;
	logic [7:0]              id_q;
	logic [7:0]              used_q;
	logic [7:0]              rem_q;
	logic [7:0]              runs_q;
	logic signed [PRI_W-1:0] pri_q;
	logic                    fin_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q   <= SLICE_RST;
			base_q    <= BASE_RST;
			penalty_q <= PENALTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLICE:   slice_q   <= cfg_wdata;
				CFG_BASE:    base_q    <= cfg_wdata;
				CFG_PENALTY: penalty_q <= cfg_wdata[3:0];
				default:     ;
			endcase
		end
	end

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// Build the request token at the head of the row
	always_comb begin
		chain[0].active   = accept;
		chain[0].dispatch = action;
		chain[0].found    = 1'b0;
		chain[0].slot     = '0;
		chain[0].id       = process_id;
		chain[0].pri      = $signed({{(PRI_W-8){1'b0}}, base_q}) -
			$signed({{(PRI_W-8){1'b0}}, need_time});
		chain[0].used     = 8'd0;
		chain[0].rem      = need_time;
		chain[0].runs     = 8'd0;
	end

	genvar k;
	generate
		for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
			pdps_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.slot_idx (SLOT_W'(k)),
				.tok_in   (chain[k]),
				.upd      (upd),
				.tok_out  (chain[k+1])
			);
		end
	endgenerate

	// Catch the token leaving the row and hold it until the output is free
	always_ff @(posedge clk) begin
		if (chain[TABLE_ENTRIES].active) begin
			tail_q <= chain[TABLE_ENTRIES];
		end
	end

	assign fin_go = pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin_go) begin
				busy_q <= 1'b0;
			end
			if (chain[TABLE_ENTRIES].active) begin
				pend_q <= 1'b1;
			end else if (fin_go) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Run one slice: age priority, advance counters
	always_comb begin
		run_len  = (slice_q < tail_q.rem) ? slice_q : tail_q.rem;
		pri_dec  = {tail_q.pri[PRI_W-1], tail_q.pri} -
			$signed({{(PRI_W-3){1'b0}}, penalty_q});
		pri_new  = (pri_dec[PRI_W] != pri_dec[PRI_W-1]) ? PRI_MIN : pri_dec[PRI_W-1:0];
		used_sum = {1'b0, tail_q.used} + {1'b0, run_len};
		used_new = used_sum[8] ? 8'hFF : used_sum[7:0];
		rem_new  = tail_q.rem - run_len;
		runs_new = (tail_q.runs == 8'hFF) ? 8'hFF : tail_q.runs + 8'd1;
		done     = (rem_new == 8'd0);
		upd.en   = fin_go && (tail_q.dispatch == ACT_DISPATCH) && tail_q.found;
		upd.slot = tail_q.slot;
		upd.pri  = pri_new;
		upd.used = used_new;
		upd.rem  = rem_new;
		upd.runs = runs_new;
		upd.done = done;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (tail_q.dispatch == ACT_DISPATCH) begin
				if (tail_q.found) begin
					status_q <= ST_DISP;
					id_q     <= tail_q.id;
					used_q   <= used_new;
					rem_q    <= rem_new;
					runs_q   <= runs_new;
					pri_q    <= pri_new;
					fin_q    <= done;
				end else begin
					status_q <= ST_NONE;
					id_q     <= 8'd0;
					used_q   <= 8'd0;
					rem_q    <= 8'd0;
					runs_q   <= 8'd0;
					pri_q    <= '0;
					fin_q    <= 1'b0;
				end
			end else begin
				status_q <= tail_q.found ? ST_LOADED : ST_FULL;
				id_q     <= tail_q.id;
				used_q   <= 8'd0;
				rem_q    <= tail_q.found ? tail_q.rem : 8'd0;
				runs_q   <= 8'd0;
				pri_q    <= tail_q.found ? tail_q.pri : '0;
				fin_q    <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign chosen_id      = id_q;
	assign used_time      = used_q;
	assign remaining_time = rem_q;
	assign run_count      = runs_q;
	assign priority_res   = pri_q;
	assign finished       = fin_q;
endmodule
`default_nettype wire

FILE: hw/rtl/pdps_checker.sv
`default_nettype none
`include "priority_decay_process_scheduler_defines.svh"
module pdps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [1:0]                         status,
	input logic [7:0]                         chosen_id,
	input logic [7:0]                         used_time,
	input logic [7:0]                         remaining_time,
	input logic [7:0]                         run_count,
	input logic signed [pdps_pkg::PRI_W-1:0]  priority_res,
	input logic                               finished
);
	import pdps_pkg::*;

	// Hold a result until it is taken
	`PDPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// An empty dispatch carries nothing
	`PDPS_ASSERT_IMPL(a_none_zero, clk, arst_n, out_valid && (status == ST_NONE), (chosen_id == 8'd0) && (used_time == 8'd0) && (remaining_time == 8'd0) && (run_count == 8'd0) && (priority_res == '0) && !finished)

	// A rejected load carries only its id
	`PDPS_ASSERT_IMPL(a_full_zero, clk, arst_n, out_valid && (status == ST_FULL), (used_time == 8'd0) && (remaining_time == 8'd0) && (run_count == 8'd0) && (priority_res == '0) && !finished)

	// A finished process has been dispatched at least once and has no time left
	`PDPS_ASSERT_IMPL(a_fin_disp, clk, arst_n, out_valid && finished, (status == ST_DISP) && (remaining_time == 8'd0) && (run_count != 8'd0))
endmodule

bind priority_decay_process_scheduler pdps_checker u_pdps_checker (.*);
`default_nettype wire

FILE: test/priority_decay_process_scheduler_tb.sv
`default_nettype none
module priority_decay_process_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdps_pkg::*;

	localparam int RING         = 4096;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AT      = 350;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = TABLE_ENTRIES + 4;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_REQS   = 90;

	// Register index past the end of the register list
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic       act;
		logic [7:0] pid;
		logic [7:0] need;
		logic       wait_idle;
	} sched_request_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [7:0]              id;
		logic [7:0]              used;
		logic [7:0]              rem;
		logic [7:0]              runs;
		logic signed [PRI_W-1:0] pri;
		logic                    fin;
	} sched_result_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [1:0] cfg_index  = '0;
	logic [7:0] cfg_wdata  = '0;
	logic       in_valid   = 1'b0;
	logic       action     = 1'b0;
	logic [7:0] process_id = '0;
	logic [7:0] need_time  = '0;
	logic       out_ready  = 1'b0;
	logic                    in_ready;
	logic                    out_valid;
	logic [1:0]              status;
	logic [7:0]              chosen_id;
	logic [7:0]              used_time;
	logic [7:0]              remaining_time;
	logic [7:0]              run_count;
	logic signed [PRI_W-1:0] priority_res;
	logic                    finished;

	// Register shadows
	logic [7:0] cfg_slice   = SLICE_RST;
	logic [7:0] cfg_base    = BASE_RST;
	logic [3:0] cfg_penalty = PENALTY_RST;

	// Process table shadow
	bit         tbl_valid [TABLE_ENTRIES];
	logic [7:0] tbl_id    [TABLE_ENTRIES];
	int         tbl_pri   [TABLE_ENTRIES];
	int         tbl_used  [TABLE_ENTRIES];
	int         tbl_rem   [TABLE_ENTRIES];
	int         tbl_runs  [TABLE_ENTRIES];

	sched_request_t pending_requests[$];
	sched_request_t cur_req;
	sched_result_t  due_results [RING];
	sched_result_t  oldest_due;
	int n_sent      = 0;
	int n_results   = 0;
	int n_errors    = 0;
	int gap_left    = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	int cycle_count = 0;
	bit hold_done   = 1'b0;
	bit tx_burst    = 1'b0;
	bit rx_burst    = 1'b0;
	bit accepted;

	priority_decay_process_scheduler u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.process_id     (process_id),
		.need_time      (need_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.chosen_id      (chosen_id),
		.used_time      (used_time),
		.remaining_time (remaining_time),
		.run_count      (run_count),
		.priority_res   (priority_res),
		.finished       (finished)
	);

	always #2 clk = ~clk;

	// Apply one request to the table shadow and return the result it yields
	function automatic sched_result_t apply_request(input sched_request_t req);
		sched_result_t res;
		int slot;
		int best;
		int run_len;
		int pri;
		res  = '0;
		slot = -1;
		best = -1;
		if (req.act == ACT_LOAD) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (slot < 0 && !tbl_valid[i]) slot = i;
			end
			res.id = req.pid;
			if (slot < 0) begin
				res.status = ST_FULL;
			end else begin
				pri             = int'(cfg_base) - int'(req.need);
				tbl_valid[slot] = 1'b1;
				tbl_id[slot]    = req.pid;
				tbl_pri[slot]   = pri;
				tbl_used[slot]  = 0;
				tbl_rem[slot]   = int'(req.need);
				tbl_runs[slot]  = 0;
				res.status      = ST_LOADED;
				res.rem         = req.need;
				res.pri         = pri[PRI_W-1:0];
			end
		end else begin
			// Highest priority, then smaller id, then lower slot
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (tbl_valid[i] && (best < 0 || tbl_pri[i] > tbl_pri[best] ||
					(tbl_pri[i] == tbl_pri[best] && tbl_id[i] < tbl_id[best])))
					best = i;
			end
			if (best < 0) begin
				res.status = ST_NONE;
			end else begin
				run_len = (int'(cfg_slice) < tbl_rem[best]) ? int'(cfg_slice) : tbl_rem[best];
				pri = tbl_pri[best] - int'(cfg_penalty);
				if (pri < int'(PRI_MIN)) pri = int'(PRI_MIN);
				tbl_pri[best]  = pri;
				tbl_used[best] = (tbl_used[best] + run_len > 255) ? 255 : tbl_used[best] + run_len;
				tbl_rem[best]  = tbl_rem[best] - run_len;
				if (tbl_runs[best] < 255) tbl_runs[best]++;
				res.status = ST_DISP;
				res.id     = tbl_id[best];
				res.used   = 8'(tbl_used[best]);
				res.rem    = 8'(tbl_rem[best]);
				res.runs   = 8'(tbl_runs[best]);
				res.pri    = pri[PRI_W-1:0];
				res.fin    = (tbl_rem[best] == 0);
				if (res.fin) tbl_valid[best] = 1'b0;
			end
		end
		return res;
	endfunction

	task automatic report(input string msg);
		$display("ERROR: %s", msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input int seq,
		input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", seq, name, got, want));
	endtask

	task automatic queue_request(input logic act, input logic [7:0] pid,
		input logic [7:0] need, input bit wait_idle = 1'b0);
		sched_request_t req;
		req.act       = act;
		req.pid       = pid;
		req.need      = need;
		req.wait_idle = wait_idle;
		pending_requests.insert(pending_requests.size(), req);
	endtask

	// Hold until every request has been answered and the block is quiet
	task automatic drain();
		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || n_results != n_sent)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_SLICE: begin
				cfg_slice = val;
			end
			CFG_BASE: begin
				cfg_base = val;
			end
			CFG_PENALTY: begin
				cfg_penalty = val[3:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: offer queued requests with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			accepted = in_valid && in_ready;
			if (accepted) begin
				due_results[n_sent % RING] <= apply_request(cur_req);
				n_sent <= n_sent + 1;
				gap_left = tx_burst ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
			end else if (!in_valid && gap_left > 0) begin
				gap_left--;
			end
			if (accepted || !in_valid) begin
				if (gap_left == 0 && pending_requests.size() != 0 &&
					(!pending_requests[0].wait_idle || (!accepted && n_results == n_sent))) begin
					cur_req = pending_requests[0];
					pending_requests.delete(0);
					action     <= cur_req.act;
					process_id <= cur_req.pid;
					need_time  <= cur_req.need;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once the run is under way
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && n_sent >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// Result monitor: compare against the oldest expectation, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (n_results >= n_sent) begin
					report($sformatf("unexpected result: status %0d id %0d", status, chosen_id));
				end else begin
					oldest_due = due_results[n_results % RING];
					check_field("status", n_results, 12'(status), 12'(oldest_due.status));
					check_field("chosen_id", n_results, 12'(chosen_id), 12'(oldest_due.id));
					check_field("used_time", n_results, 12'(used_time), 12'(oldest_due.used));
					check_field("remaining_time", n_results, 12'(remaining_time),
						12'(oldest_due.rem));
					check_field("run_count", n_results, 12'(run_count), 12'(oldest_due.runs));
					check_field("priority_res", n_results, priority_res, oldest_due.pri);
					check_field("finished", n_results, 12'(finished), 12'(oldest_due.fin));
					n_results <= n_results + 1;
				end
				stall_left = rx_burst ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0) && (hold_left == 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int load_pct;
		logic [7:0] slice_val;
		logic [7:0] base_val;
		logic [3:0] pen_val;
		logic [7:0] pid;
		logic [7:0] need;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: empty table, extremes, duplicates, full table
		queue_request(ACT_DISPATCH, 8'hA5, 8'h5A);
		queue_request(ACT_LOAD, 8'hFF, 8'h00);
		queue_request(ACT_LOAD, 8'h00, 8'hFF);
		queue_request(ACT_LOAD, 8'd10, 8'd5);
		queue_request(ACT_LOAD, 8'd10, 8'd5);
		queue_request(ACT_LOAD, 8'd3, 8'd50);
		queue_request(ACT_LOAD, 8'd200, 8'd1);
		queue_request(ACT_LOAD, 8'd7, 8'd20);
		queue_request(ACT_LOAD, 8'd1, 8'd20);
		queue_request(ACT_LOAD, 8'h55, 8'hAA);
		for (int k = 0; k < 10; k++)
			queue_request(ACT_DISPATCH, 8'($urandom), 8'($urandom));
		queue_request(ACT_LOAD, 8'h2A, 8'd0);
		queue_request(ACT_DISPATCH, 8'h00, 8'h00);
		drain();

		// Zero slice, harshest penalty: load one more process and age the whole table with
		// dispatches that run no time, then dispatch twice with the widest slice
		write_reg(CFG_SLICE, 8'd0);
		write_reg(CFG_BASE, 8'd0);
		write_reg(CFG_PENALTY, 8'hFF);
		@(negedge clk);
		queue_request(ACT_LOAD, 8'h5A, 8'hFF);
		for (int k = 0; k < 270; k++)
			queue_request(ACT_DISPATCH, 8'($urandom), 8'($urandom));
		drain();
		write_reg(CFG_SLICE, 8'hFF);
		@(negedge clk);
		queue_request(ACT_DISPATCH, 8'h00, 8'h00);
		queue_request(ACT_DISPATCH, 8'h00, 8'h00);

		// Random phases, each under its own settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					slice_val = 8'd1;
					base_val  = 8'd0;
					pen_val   = 4'd0;
				end
				1: begin
					slice_val = 8'd255;
					base_val  = 8'd255;
					pen_val   = 4'd15;
				end
				default: begin
					slice_val = 8'($urandom_range(1, 12));
					base_val  = 8'($urandom);
					pen_val   = 4'($urandom);
				end
			endcase
			write_reg(CFG_SLICE, slice_val);
			write_reg(CFG_BASE, base_val);
			write_reg(CFG_PENALTY, {4'($urandom), pen_val});
			if (ph == 2) write_reg(CFG_UNUSED, 8'($urandom));
			@(negedge clk);
			load_pct = $urandom_range(25, 75);
			for (int k = 0; k < PHASE_REQS; k++) begin
				// Small id pool for ties, short needs so processes finish
				pid  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				need = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
				queue_request(($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_DISPATCH,
					pid, need, $urandom_range(0, 59) == 0);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
